// File: sv/rtrd_pkg.sv
// rtrd_pkg: shared types and constants for the residual and temporal run decoder
// no dependencies; used by every module of the decoder
`default_nettype none

package rtrd_pkg;

    // widths of the stream fields
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned COEF_W = 14;
    localparam int unsigned RUN_W  = 31;

    // output tdata width: coefficient and run packed, filled up to whole bytes
    localparam int unsigned OUT_DATA_W = ((COEF_W + RUN_W + 7) / 8) * 8;

    // saturated run count; an accumulator above RUN_MAX >> 7 saturates to it on the next chained group
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // decode kinds held in the configuration register
    localparam logic KIND_RESIDUAL = 1'b0;
    localparam logic KIND_TEMPORAL = 1'b1;

    // parse phase
    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_HIGH = 2'd1,
        PH_RUN  = 2'd2
    } phase_t;

    // one decoded result word
    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [RUN_W-1:0]         run_length;
        logic                     temporal_flag;
    } result_t;

    // append one 7-bit group to a run count, saturating at the top
    function automatic logic [RUN_W-1:0] chain_run(
        input logic [RUN_W-1:0]  acc,
        input logic [BYTE_W-1:0] b
    );
        logic [RUN_W-1:0] res;
        begin
            if (|acc[RUN_W-1:RUN_W-7])
            begin
                res = RUN_MAX;
            end
            else
            begin
                res = {acc[RUN_W-8:0], b[6:0]};
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/residual_and_temporal_run_decoder.sv
// residual_and_temporal_run_decoder: top level of the run-length symbol decoder
// depends on rtrd_pkg, rtrd_in_stage, rtrd_parse and rtrd_out_stage
//
//  channel  | dir | handshake          | contents
//  s_*      | in  | s_tvalid/s_tready  | tdata[7:0] data_byte, tuser chunk_start
//  m_*      | out | m_tvalid/m_tready  | tdata[13:0] coefficient, [44:14] run_length,
//           |     |                    | tuser temporal_flag
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_data decode_kind
//
// one byte per cycle while the result register is not stalled: a byte is held in the input
// register until the parse logic consumes it and loads its outcome into the result register
// the result word is registered in the output register when its last byte leaves the input register
// reset clears the parse state and selects residual mode; cfg_ready is always high
// a stalled result holds the output register; one more byte is still taken
// into the input register before s_tready drops
`default_nettype none

module residual_and_temporal_run_decoder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [rtrd_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
    input  wire logic                                s_tuser,   // [0] chunk_start
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [rtrd_pkg::OUT_DATA_W-1:0]          m_tdata,   // [13:0] coefficient, [44:14] run_length
    output logic                                     m_tuser,   // [0] temporal_flag
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_data   // [0] decode_kind
);

    logic                        in_valid;
    logic [rtrd_pkg::BYTE_W-1:0] in_byte;
    logic                        in_start;
    logic                        advance;
    logic                        emit;
    rtrd_pkg::result_t           result;

    // a byte is consumed when the result register can take its outcome
    assign advance   = in_valid & (~m_tvalid | m_tready);
    assign cfg_ready = 1'b1;

    rtrd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_start (in_start)
    );

    rtrd_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_valid & cfg_ready),
        .cfg_kind (cfg_data),
        .advance  (advance),
        .in_byte  (in_byte),
        .in_start (in_start),
        .emit     (emit),
        .result   (result)
    );

    rtrd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .emit     (emit),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: sv/rtrd_in_stage.sv
// rtrd_in_stage: input register of the decoder, holds one accepted byte word
// depends on rtrd_pkg for field widths
`default_nettype none

module rtrd_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [rtrd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                        s_tuser,   // [0] chunk_start
    input  wire logic                        advance,
    output logic                             in_valid,
    output logic [rtrd_pkg::BYTE_W-1:0]      in_byte,
    output logic                             in_start
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [rtrd_pkg::BYTE_W-1:0] byte_reg;
    logic                        start_reg;

    // a word may enter when the register is empty or is drained this cycle
    assign s_tready   = ~valid_reg | advance;
    assign valid_next = (s_tvalid & s_tready) | (valid_reg & ~advance);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_start = start_reg;

endmodule

`default_nettype wire

// File: sv/rtrd_parse.sv
// rtrd_parse: parse state, configuration register and per-byte decode logic
// depends on rtrd_pkg for phase type, result struct and run chaining
`default_nettype none

module rtrd_parse (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr,
    input  wire logic                        cfg_kind,
    input  wire logic                        advance,
    input  wire logic [rtrd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                        in_start,
    output logic                             emit,
    output rtrd_pkg::result_t                result
);

    logic                              kind_reg;
    rtrd_pkg::phase_t                  phase_reg;
    rtrd_pkg::phase_t                  phase_next;
    logic [rtrd_pkg::BYTE_W-1:0]       pend_reg;
    logic [rtrd_pkg::BYTE_W-1:0]       pend_next;
    logic [rtrd_pkg::COEF_W-1:0]       held_reg;
    logic [rtrd_pkg::COEF_W-1:0]       held_next;
    logic [rtrd_pkg::RUN_W-1:0]        acc_reg;
    logic [rtrd_pkg::RUN_W-1:0]        acc_next;
    logic                              cur_reg;
    logic                              cur_next;
    logic                              owner_reg;
    logic                              owner_next;
    logic                              seen_reg;
    logic                              seen_next;

    // state as seen by this byte after a chunk start clear
    rtrd_pkg::phase_t                  ph_eff;
    logic [rtrd_pkg::RUN_W-1:0]        acc_eff;
    logic                              cur_eff;
    logic                              seen_eff;
    logic [rtrd_pkg::RUN_W-1:0]        acc_base;
    logic [rtrd_pkg::RUN_W-1:0]        acc_chain;
    logic [rtrd_pkg::COEF_W-1:0]       val_short;
    logic [rtrd_pkg::COEF_W-1:0]       val_long;

    assign ph_eff   = in_start ? rtrd_pkg::PH_LOW : phase_reg;
    assign acc_eff  = in_start ? '0 : acc_reg;
    assign cur_eff  = in_start ? 1'b0 : cur_reg;
    assign seen_eff = in_start ? 1'b0 : seen_reg;

    // value of a one-byte coefficient: bits 6..1 less 32, sign extended
    assign val_short = {{(rtrd_pkg::COEF_W-5){~in_byte[6]}}, in_byte[5:1]};
    // value of a two-byte coefficient: the offset subtract flips the top bit
    assign val_long  = {~in_byte[6], in_byte[5:0], pend_reg[7:1]};

    // temporal runs restart the count outside a run; residual runs always chain
    assign acc_base  = (kind_reg == rtrd_pkg::KIND_TEMPORAL && ph_eff != rtrd_pkg::PH_RUN)
                       ? '0 : acc_eff;
    assign acc_chain = rtrd_pkg::chain_run(acc_base, in_byte);

    // next state and result
    always_comb
    begin
        phase_next = ph_eff;
        pend_next  = pend_reg;
        held_next  = held_reg;
        acc_next   = acc_eff;
        cur_next   = cur_eff;
        owner_next = owner_reg;
        seen_next  = seen_eff;
        emit       = 1'b0;
        result     = '0;
        if (kind_reg == rtrd_pkg::KIND_TEMPORAL)
        begin
            if (!seen_eff)
            begin
                seen_next  = 1'b1;
                cur_next   = in_byte[0];
                phase_next = rtrd_pkg::PH_LOW;
            end
            else
            begin
                if (ph_eff != rtrd_pkg::PH_RUN)
                begin
                    owner_next = cur_eff;
                end
                acc_next = acc_chain;
                if (in_byte[7])
                begin
                    phase_next = rtrd_pkg::PH_RUN;
                end
                else
                begin
                    cur_next             = ~cur_eff;
                    phase_next           = rtrd_pkg::PH_LOW;
                    emit                 = 1'b1;
                    result.run_length    = acc_chain;
                    result.temporal_flag = owner_next;
                end
            end
        end
        else
        begin
            case (ph_eff)
                rtrd_pkg::PH_HIGH:
                begin
                    held_next = val_long;
                    acc_next  = '0;
                    if (in_byte[7])
                    begin
                        phase_next = rtrd_pkg::PH_RUN;
                    end
                    else
                    begin
                        phase_next         = rtrd_pkg::PH_LOW;
                        emit               = 1'b1;
                        result.coefficient = val_long;
                    end
                end
                rtrd_pkg::PH_RUN:
                begin
                    acc_next = acc_chain;
                    if (!in_byte[7])
                    begin
                        phase_next         = rtrd_pkg::PH_LOW;
                        emit               = 1'b1;
                        result.coefficient = held_reg;
                        result.run_length  = acc_chain;
                    end
                end
                default:
                begin
                    if (in_byte[0])
                    begin
                        pend_next  = in_byte;
                        phase_next = rtrd_pkg::PH_HIGH;
                    end
                    else
                    begin
                        held_next = val_short;
                        acc_next  = '0;
                        if (in_byte[7])
                        begin
                            phase_next = rtrd_pkg::PH_RUN;
                        end
                        else
                        begin
                            phase_next         = rtrd_pkg::PH_LOW;
                            emit               = 1'b1;
                            result.coefficient = val_short;
                        end
                    end
                end
            endcase
        end
    end

    // state registers; a configuration write clears the partial decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= rtrd_pkg::KIND_RESIDUAL;
            phase_reg <= rtrd_pkg::PH_LOW;
            pend_reg  <= '0;
            held_reg  <= '0;
            acc_reg   <= '0;
            cur_reg   <= 1'b0;
            owner_reg <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            kind_reg  <= cfg_kind;
            phase_reg <= rtrd_pkg::PH_LOW;
            acc_reg   <= '0;
            cur_reg   <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            held_reg  <= held_next;
            acc_reg   <= acc_next;
            cur_reg   <= cur_next;
            owner_reg <= owner_next;
            seen_reg  <= seen_next;
        end
    end

    // temporal results never carry a coefficient
    a_temporal_no_coef: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && kind_reg == rtrd_pkg::KIND_TEMPORAL) |-> (result.coefficient == '0))
        else $error("temporal result with nonzero coefficient");

    // residual results never carry a temporal flag
    a_residual_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && kind_reg == rtrd_pkg::KIND_RESIDUAL) |-> !result.temporal_flag)
        else $error("residual result with temporal flag set");

    // parse state holds while no byte is consumed and no register write occurs
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && !cfg_wr) |=> ($stable(phase_reg) && $stable(acc_reg) && $stable(seen_reg)))
        else $error("parse state moved without a consumed byte");

    // a run count only saturates, never wraps: chaining from a saturated count stays there
    a_run_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_wr && !in_start && phase_reg == rtrd_pkg::PH_RUN
         && acc_reg == rtrd_pkg::RUN_MAX) |=> (acc_reg == rtrd_pkg::RUN_MAX))
        else $error("saturated run count changed inside a run");

endmodule

`default_nettype wire

// File: sv/rtrd_out_stage.sv
// rtrd_out_stage: result register driving the master-side stream
// depends on rtrd_pkg for the result struct and packing widths
`default_nettype none

module rtrd_out_stage (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic                            emit,
    input  wire rtrd_pkg::result_t               result,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rtrd_pkg::OUT_DATA_W-1:0]      m_tdata,   // [13:0] coefficient, [44:14] run_length
    output logic                                 m_tuser    // [0] temporal_flag
);

    localparam int unsigned PAD_W = rtrd_pkg::OUT_DATA_W - rtrd_pkg::COEF_W - rtrd_pkg::RUN_W;

    logic              valid_reg;
    logic              valid_next;
    rtrd_pkg::result_t res_reg;

    // advance only happens while the register is empty or being drained
    assign valid_next = advance ? emit : (valid_reg & ~m_tready);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_reg <= result;
        end
    end

    // word packing
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, res_reg.run_length, res_reg.coefficient};
    assign m_tuser  = res_reg.temporal_flag;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for residual_and_temporal_run_decoder
// depends on rtrd_pkg and the decoder RTL; a byte-level predictor checks every result word

module testbench;

    localparam int unsigned LIMIT_CYCLES     = 200000;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned RANDOM_PER_PHASE = 128;
    localparam int unsigned MAX_REPORTS      = 10;

    // bias removed from the two value forms after the halving shift
    localparam logic [rtrd_pkg::COEF_W-1:0] WIDE_BIAS   = 14'h2000;
    localparam logic [rtrd_pkg::COEF_W-1:0] NARROW_BIAS = 14'h0020;

    typedef struct packed {
        logic [rtrd_pkg::BYTE_W-1:0] data;
        logic                        start;
    } sym_t;

    typedef enum logic [1:0] {
        IDLE_NONE = 2'd0,
        IDLE_SEND = 2'd1,
        IDLE_RECV = 2'd2,
        IDLE_BOTH = 2'd3
    } idle_mode_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [rtrd_pkg::BYTE_W-1:0]     s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [rtrd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic                            cfg_data  = rtrd_pkg::KIND_RESIDUAL;

    idle_mode_t  idle_mode      = IDLE_NONE;
    int unsigned cycle_count    = 0;
    int unsigned bytes_queued   = 0;
    int unsigned bytes_taken    = 0;
    int unsigned words_checked  = 0;
    int unsigned kind_writes    = 0;
    int unsigned mismatch_count = 0;

    sym_t              byte_q[$];
    rtrd_pkg::result_t expected_words[$];

    // decoder state as predicted by the bench
    logic                        dec_kind;
    rtrd_pkg::phase_t            dec_phase;
    logic [rtrd_pkg::BYTE_W-1:0] dec_low;
    logic [rtrd_pkg::COEF_W-1:0] dec_held;
    logic [rtrd_pkg::RUN_W-1:0]  dec_run;
    logic                        dec_temporal;
    logic                        dec_owner;
    logic                        dec_seen;

    residual_and_temporal_run_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shift one 7-bit group into a run count, pinning at the top once it would overflow
    function automatic logic [rtrd_pkg::RUN_W-1:0] grow_run(
        input logic [rtrd_pkg::RUN_W-1:0] acc,
        input logic [6:0]                 grp
    );
        logic [rtrd_pkg::RUN_W-1:0] nxt;
        if (acc > (rtrd_pkg::RUN_MAX >> 7))
            nxt = rtrd_pkg::RUN_MAX;
        else
            nxt = {acc[rtrd_pkg::RUN_W-8:0], grp};
        return nxt;
    endfunction

    // chunk start and register writes drop any partial decode
    task automatic clear_parse_state;
        dec_phase    = rtrd_pkg::PH_LOW;
        dec_run      = '0;
        dec_temporal = 1'b0;
        dec_seen     = 1'b0;
    endtask

    task automatic push_expected(
        input logic [rtrd_pkg::COEF_W-1:0] coef,
        input logic [rtrd_pkg::RUN_W-1:0]  run,
        input logic                        flag
    );
        rtrd_pkg::result_t w;
        w.coefficient   = coef;
        w.run_length    = run;
        w.temporal_flag = flag;
        expected_words.push_back(w);
    endtask

    // advance the predicted parse state by one accepted word
    task automatic decode_byte(input sym_t s);
        logic [rtrd_pkg::BYTE_W-1:0] b;
        b = s.data;
        if (s.start)
            clear_parse_state();
        if (dec_kind == rtrd_pkg::KIND_TEMPORAL)
        begin
            if (!dec_seen)
            begin
                // first byte of the chunk only sets the state
                dec_seen     = 1'b1;
                dec_temporal = b[0];
                dec_phase    = rtrd_pkg::PH_LOW;
            end
            else
            begin
                if (dec_phase != rtrd_pkg::PH_RUN)
                begin
                    dec_owner = dec_temporal;
                    dec_run   = '0;
                end
                dec_run = grow_run(dec_run, b[6:0]);
                if (b[7])
                    dec_phase = rtrd_pkg::PH_RUN;
                else
                begin
                    dec_temporal = ~dec_temporal;
                    dec_phase    = rtrd_pkg::PH_LOW;
                    push_expected('0, dec_run, dec_owner);
                end
            end
        end
        else if (dec_phase == rtrd_pkg::PH_RUN)
        begin
            dec_run = grow_run(dec_run, b[6:0]);
            if (!b[7])
            begin
                dec_phase = rtrd_pkg::PH_LOW;
                push_expected(dec_held, dec_run, 1'b0);
            end
        end
        else if (dec_phase == rtrd_pkg::PH_LOW && b[0])
        begin
            // two-byte value, wait for the high byte
            dec_low   = b;
            dec_phase = rtrd_pkg::PH_HIGH;
        end
        else
        begin
            if (dec_phase == rtrd_pkg::PH_HIGH)
                dec_held = {b[6:0], dec_low[7:1]} - WIDE_BIAS;
            else
                dec_held = {8'd0, b[6:1]} - NARROW_BIAS;
            dec_run = '0;
            if (b[7])
                dec_phase = rtrd_pkg::PH_RUN;
            else
            begin
                dec_phase = rtrd_pkg::PH_LOW;
                push_expected(dec_held, '0, 1'b0);
            end
        end
    endtask

    function automatic logic pause_now(input logic sender);
        logic hit;
        hit = 1'b0;
        if (idle_mode == IDLE_BOTH)
            hit = ($urandom_range(99) < 6);
        else if ((sender && idle_mode == IDLE_SEND) || (!sender && idle_mode == IDLE_RECV))
            hit = ($urandom_range(99) < 81);
        return hit;
    endfunction

    // input driver: predicts each word at the edge it is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(sym_t'({s_tdata, s_tuser}));
                bytes_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_q.size() != 0 && !pause_now(1'b1))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_q[0].data;
                    s_tuser  <= byte_q[0].start;
                    void'(byte_q.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        rtrd_pkg::result_t got;
        rtrd_pkg::result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.coefficient   = m_tdata[rtrd_pkg::COEF_W-1:0];
                got.run_length    = m_tdata[rtrd_pkg::COEF_W+rtrd_pkg::RUN_W-1:rtrd_pkg::COEF_W];
                got.temporal_flag = m_tuser;
                if (expected_words.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: unexpected word coef %0d run %0d flag %0b", $realtime,
                                 got.coefficient, got.run_length, got.temporal_flag);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (got.coefficient !== want.coefficient ||
                        got.run_length !== want.run_length ||
                        got.temporal_flag !== want.temporal_flag)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("%0t: coef/run/flag exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     $realtime, want.coefficient, want.run_length,
                                     want.temporal_flag, got.coefficient, got.run_length,
                                     got.temporal_flag);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= !pause_now(1'b0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_sym(input logic [rtrd_pkg::BYTE_W-1:0] d, input logic st);
        byte_q.push_back('{data: d, start: st});
        bytes_queued++;
    endtask

    // run groups: continuation bit on all but the last
    task automatic push_run_groups(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            push_sym({(i + 1 < n), 7'($urandom)}, 1'b0);
    endtask

    // mostly short runs, now and then long enough to saturate
    function automatic int unsigned pick_groups();
        int unsigned n;
        if ($urandom_range(15) == 0)
            n = $urandom_range(6, 4);
        else
            n = $urandom_range(3, 1);
        return n;
    endfunction

    task automatic push_residual_symbol;
        logic [rtrd_pkg::BYTE_W-1:0] lo;
        logic [rtrd_pkg::BYTE_W-1:0] hi;
        logic                        has_run;
        logic                        st;
        lo      = 8'($urandom);
        hi      = 8'($urandom);
        has_run = 1'($urandom_range(1));
        st      = ($urandom_range(19) == 0);
        if (lo[0])
        begin
            hi[7] = has_run;
            push_sym(lo, st);
            push_sym(hi, 1'b0);
        end
        else
        begin
            lo[7] = has_run;
            push_sym(lo, st);
        end
        if (has_run)
            push_run_groups(pick_groups());
    endtask

    task automatic push_temporal_run;
        if ($urandom_range(19) == 0)
            push_sym(8'($urandom), 1'b1);
        push_run_groups(pick_groups());
    endtask

    // wait for all words taken and all results back, then let the pipeline settle
    task automatic wait_idle;
        while (bytes_taken != bytes_queued || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_kind(input logic kind);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= kind;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        dec_kind = kind;
        clear_parse_state();
        kind_writes++;
    endtask

    // stimulus sequencer
    initial
    begin
        int unsigned target;
        dec_kind  = rtrd_pkg::KIND_RESIDUAL;
        dec_low   = '0;
        dec_held  = '0;
        dec_owner = 1'b0;
        clear_parse_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // residual: zero, both single-byte extremes, both two-byte extremes, chained run
        write_kind(rtrd_pkg::KIND_RESIDUAL);
        push_sym(8'h40, 1'b0);
        push_sym(8'h00, 1'b0);
        push_sym(8'h7E, 1'b0);
        push_sym(8'h01, 1'b0);
        push_sym(8'h00, 1'b0);
        push_sym(8'hFF, 1'b0);
        push_sym(8'h7F, 1'b0);
        push_sym(8'h82, 1'b0);
        push_sym(8'h85, 1'b0);
        push_sym(8'h03, 1'b0);
        // chunk start drops a pending low byte
        push_sym(8'h01, 1'b0);
        push_sym(8'h10, 1'b1);
        // left hanging so the register write has to clear it
        push_sym(8'h01, 1'b0);
        wait_idle();

        // temporal: state byte, plain run, chained zero run, saturated run, restart
        write_kind(rtrd_pkg::KIND_TEMPORAL);
        push_sym(8'h01, 1'b1);
        push_sym(8'h05, 1'b0);
        push_sym(8'h80, 1'b0);
        push_sym(8'h00, 1'b0);
        repeat (5) push_sym(8'hFF, 1'b0);
        push_sym(8'h7F, 1'b0);
        push_sym(8'h03, 1'b1);
        push_sym(8'h7F, 1'b0);
        wait_idle();

        // random phases: each idle mode with each decode kind
        for (int p = 0; p < 8; p++)
        begin
            idle_mode = idle_mode_t'(p / 2);
            write_kind(p % 2 == 1 ? rtrd_pkg::KIND_TEMPORAL : rtrd_pkg::KIND_RESIDUAL);
            target = bytes_queued + RANDOM_PER_PHASE;
            while (bytes_queued < target)
            begin
                if ($urandom_range(9) == 0)
                    push_sym(8'($urandom), ($urandom_range(3) == 0));
                else if (dec_kind == rtrd_pkg::KIND_TEMPORAL)
                    push_temporal_run();
                else
                    push_residual_symbol();
            end
            wait_idle();
        end

        $display("covered %0d symbol bytes across %0d decode kind writes and four idle modes",
                 bytes_taken, kind_writes);
        $display("checked %0d result words, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
sv/rtrd_pkg.sv
sv/rtrd_in_stage.sv
sv/rtrd_parse.sv
sv/rtrd_out_stage.sv
sv/residual_and_temporal_run_decoder.sv
verif/testbench.sv
